### design/hid_keyboard_report_to_keys_assert.svh
// Assertion macros for the keyboard decoder RTL.
`ifndef HID_KEYBOARD_REPORT_TO_KEYS_ASSERT_SVH
`define HID_KEYBOARD_REPORT_TO_KEYS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define HKR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hkr assertion failed");

// Next-cycle implication, checked out of reset.
`define HKR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hkr assertion failed");

`else

`define HKR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HKR_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### design/hkr_pkg.sv
`timescale 1ns / 1ps

package hkr_pkg;

    localparam int NSLOTS              = 6;
    localparam int KEYS_PER_REPORT_DEF = 6;

    localparam logic [31:0] DEF_DELAY    = 32'd600;
    localparam logic [31:0] DEF_INTERVAL = 32'd150;

    // input kinds
    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_FIRST_DELAY     = 2'd0;
    localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_TICK_CHECK,
        ST_TICK_CATCH,
        ST_EMIT
    } state_t;

    // per-slot findings
    typedef struct packed {
        logic       fresh;      // usage > 3 and not in previous report
        logic       code_nz;    // translation is nonzero
        logic       held_match; // slot holds the current held usage
        logic [7:0] usage;
        logic [7:0] code;
    } lane_t;

    // hold-state update from the merge stage
    typedef struct packed {
        logic       on;
        logic       fresh;      // restart first delay
        logic [7:0] usage;
        logic [7:0] code;
    } hold_t;

    // {unshifted, shifted} for usages below 57
    function automatic logic [15:0] hkr_ascii(input logic [7:0] u);
        logic [15:0] r;
        r = 16'h0000;
        case (u) inside
            [8'd4:8'd29]:  r = {u + 8'h5D, u + 8'h3D};
            8'd30: r = {8'h31, 8'h21};
            8'd31: r = {8'h32, 8'h40};
            8'd32: r = {8'h33, 8'h23};
            8'd33: r = {8'h34, 8'h24};
            8'd34: r = {8'h35, 8'h25};
            8'd35: r = {8'h36, 8'h5E};
            8'd36: r = {8'h37, 8'h26};
            8'd37: r = {8'h38, 8'h2A};
            8'd38: r = {8'h39, 8'h28};
            8'd39: r = {8'h30, 8'h29};
            8'd40: r = {8'h0D, 8'h0D};
            8'd41: r = {8'h1B, 8'h1B};
            8'd42: r = {8'h08, 8'h08};
            8'd43: r = {8'h09, 8'h09};
            8'd44: r = {8'h20, 8'h20};
            8'd45: r = {8'h2D, 8'h5F};
            8'd46: r = {8'h3D, 8'h2B};
            8'd47: r = {8'h5B, 8'h7B};
            8'd48: r = {8'h5D, 8'h7D};
            8'd49: r = {8'h5C, 8'h7C};
            8'd50: r = {8'h5C, 8'h7C};
            8'd51: r = {8'h3B, 8'h3A};
            8'd52: r = {8'h27, 8'h22};
            8'd53: r = {8'h60, 8'h7E};
            8'd54: r = {8'h2C, 8'h3C};
            8'd55: r = {8'h2E, 8'h3E};
            8'd56: r = {8'h2F, 8'h3F};
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hkr_nav(input logic [7:0] u);
        logic [7:0] r;
        r = 8'h00;
        case (u)
            8'h49: r = 8'h84; // Insert
            8'h4A: r = 8'h86; // Home
            8'h4B: r = 8'h88; // PgUp
            8'h4C: r = 8'h7F; // Delete
            8'h4D: r = 8'h87; // End
            8'h4E: r = 8'h89; // PgDn
            8'h4F: r = 8'h83; // Right
            8'h50: r = 8'h82; // Left
            8'h51: r = 8'h81; // Down
            8'h52: r = 8'h80; // Up
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hkr_xlate(input logic [7:0] mods, input logic [7:0] u);
        logic [15:0] pair;
        logic [7:0]  r;
        pair = hkr_ascii(u);
        if ((u inside {[8'h04:8'h1D]}) && ((mods & 8'h11) != 8'h00)) begin
            r = u - 8'h03;
        end else if (u < 8'd57) begin
            r = ((mods & 8'h22) != 8'h00) ? pair[7:0] : pair[15:8];
        end else if (u inside {[8'h3A:8'h45]}) begin
            r = u + 8'h57; // F1..F12 -> 0x91..0x9C
        end else begin
            r = hkr_nav(u);
        end
        return r;
    endfunction

endpackage

### design/hkr_lane.sv
`timescale 1ns / 1ps

module hkr_lane #(
    parameter int K = 6
) (
    input  logic [7:0]          key,
    input  logic [7:0]          mods,
    input  logic [K-1:0][7:0]   prev_keys,
    input  logic [7:0]          held_usage,
    output hkr_pkg::lane_t      lane
);
    import hkr_pkg::*;

    logic       seen;
    logic [7:0] code;

    always_comb begin
        seen = 1'b0;
        for (int j = 0; j < K; j++) begin
            if (prev_keys[j] == key) seen = 1'b1;
        end
    end

    assign code = hkr_xlate(mods, key);

    always_comb begin
        lane.fresh      = (key > 8'd3) && !seen;
        lane.code_nz    = (code != 8'h00);
        lane.held_match = (key == held_usage);
        lane.usage      = key;
        lane.code       = code;
    end

endmodule

### design/hkr_merge.sv
`timescale 1ns / 1ps

module hkr_merge #(
    parameter int K = 6
) (
    input  hkr_pkg::lane_t [K-1:0] lanes,
    input  logic                   repeat_on,
    output logic [K-1:0]           emit_mask,
    output hkr_pkg::hold_t         hold
);
    import hkr_pkg::*;

    logic       new_any, new_nz;
    logic [7:0] new_usage, new_code;
    logic       nz_any;
    logic [7:0] nz_usage, nz_code;
    logic       hit_any, hit_nz;
    logic [7:0] hit_usage, hit_code;

    // last new slot decides the hold left by the press pass
    always_comb begin
        new_any   = 1'b0;
        new_nz    = 1'b0;
        new_usage = 8'h00;
        new_code  = 8'h00;
        for (int i = 0; i < K; i++) begin
            emit_mask[i] = lanes[i].fresh & lanes[i].code_nz;
            if (lanes[i].fresh) begin
                new_any   = 1'b1;
                new_nz    = lanes[i].code_nz;
                new_usage = lanes[i].usage;
                new_code  = lanes[i].code;
            end
        end
    end

    // first nonzero slot and first slot matching the held usage
    always_comb begin
        nz_any    = 1'b0;
        nz_usage  = 8'h00;
        nz_code   = 8'h00;
        hit_any   = 1'b0;
        hit_nz    = 1'b0;
        hit_usage = 8'h00;
        hit_code  = 8'h00;
        for (int i = K - 1; i >= 0; i--) begin
            if (lanes[i].code_nz) begin
                nz_any   = 1'b1;
                nz_usage = lanes[i].usage;
                nz_code  = lanes[i].code;
            end
            if (lanes[i].held_match) begin
                hit_any   = 1'b1;
                hit_nz    = lanes[i].code_nz;
                hit_usage = lanes[i].usage;
                hit_code  = lanes[i].code;
            end
        end
    end

    always_comb begin
        hold = '0;
        if (!new_any && repeat_on && hit_any) begin
            // held key still down: refresh code, drop if it turned zero
            if (hit_nz) begin
                hold.on    = 1'b1;
                hold.usage = hit_usage;
                hold.code  = hit_code;
            end
        end else if (new_any && new_nz) begin
            hold.on    = 1'b1;
            hold.fresh = 1'b1;
            hold.usage = new_usage;
            hold.code  = new_code;
        end else if (nz_any) begin
            hold.on    = 1'b1;
            hold.fresh = 1'b1;
            hold.usage = nz_usage;
            hold.code  = nz_code;
        end
    end

endmodule

### design/hid_keyboard_report_to_keys.sv
`timescale 1ns / 1ps
// Channel | Ports                                   | Dir | Beat
// s_      | s_kind s_modifiers s_key_0..s_key_5     | in  | one report / tick / clear
// m_      | m_char_code m_last_of_run               | out | one translated code
// cfg_    | cfg_index cfg_data                      | in  | one register write
//
// A report passes ST_EVAL, then ST_EMIT for each emitted code (up to K total); a tick
// passes ST_EVAL and ST_TICK_CHECK, plus ST_TICK_CATCH and ST_EMIT with a repeat code.
// The buffer drains one code per cycle into the output register unless m_ready stalls it.
// Reset (aresetn low, synchronous) clears previous keys, hold state, time and
// registers to 600/150. m_ready low stalls the emit drain; s_ready is high in idle,
// also while the last code still sits in the output register.

`include "hid_keyboard_report_to_keys_assert.svh"

module hid_keyboard_report_to_keys #(
    parameter int KEYS_PER_REPORT = hkr_pkg::KEYS_PER_REPORT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // report / tick / clear beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_modifiers,
    input  logic [7:0]  s_key_0,
    input  logic [7:0]  s_key_1,
    input  logic [7:0]  s_key_2,
    input  logic [7:0]  s_key_3,
    input  logic [7:0]  s_key_4,
    input  logic [7:0]  s_key_5,
    // translated code beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_code,
    output logic        m_last_of_run,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import hkr_pkg::*;

    localparam int K = KEYS_PER_REPORT;

    // FSM and control
    state_t         state_reg, state_next;
    logic           m_valid_reg, m_valid_next;
    logic [K-1:0]   emit_mask_reg, emit_mask_next;

    // model state
    logic [K-1:0][7:0] prev_keys_reg, prev_keys_next;
    logic [7:0]     held_usage_reg, held_usage_next;
    logic [7:0]     held_code_reg, held_code_next;
    logic           repeat_on_reg, repeat_on_next;
    logic [31:0]    due_reg, due_next;
    logic [31:0]    time_now_reg, time_now_next;
    logic [15:0]    first_delay_reg;
    logic [15:0]    repeat_interval_reg;

    // payload
    logic [1:0]        kind_reg;
    logic [7:0]        mods_reg;
    logic [K-1:0][7:0] key_reg;
    logic [K-1:0][7:0] emit_code_reg, emit_code_next;
    logic [7:0]        m_char_code_reg, m_char_code_next;
    logic              m_last_reg, m_last_next;

    logic [NSLOTS-1:0][7:0] keys_in;
    lane_t [K-1:0]  lane_res;
    logic [K-1:0]   rpt_mask;
    hold_t          hold;

    logic           s_fire;
    logic           out_load;
    logic [K-1:0]   sel_onehot;
    logic [K-1:0]   mask_left;
    logic [7:0]     sel_code;
    logic [31:0]    delay_eff;
    logic [31:0]    iv_eff;
    logic [31:0]    due_diff;
    logic           tick_hit;

    assign keys_in[0] = s_key_0;
    assign keys_in[1] = s_key_1;
    assign keys_in[2] = s_key_2;
    assign keys_in[3] = s_key_3;
    assign keys_in[4] = s_key_4;
    assign keys_in[5] = s_key_5;

    // one lane per report slot
    for (genvar gi = 0; gi < K; gi++) begin : g_lane
        hkr_lane #(.K(K)) u_lane (
            .key        (key_reg[gi]),
            .mods       (mods_reg),
            .prev_keys  (prev_keys_reg),
            .held_usage (held_usage_reg),
            .lane       (lane_res[gi])
        );
    end

    hkr_merge #(.K(K)) u_merge (
        .lanes     (lane_res),
        .repeat_on (repeat_on_reg),
        .emit_mask (rpt_mask),
        .hold      (hold)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid       = m_valid_reg;
    assign m_char_code   = m_char_code_reg;
    assign m_last_of_run = m_last_reg;

    // zero register value selects the default
    assign delay_eff = (first_delay_reg == 16'd0) ? DEF_DELAY : {16'd0, first_delay_reg};
    assign iv_eff    = (repeat_interval_reg == 16'd0) ? DEF_INTERVAL
                                                       : {16'd0, repeat_interval_reg};

    // due when (now - due) has bit 31 clear
    assign due_diff = time_now_reg - due_reg;
    assign tick_hit = repeat_on_reg && (held_code_reg != 8'h00) && !due_diff[31];

    // lowest pending code goes out first
    assign out_load   = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign sel_onehot = emit_mask_reg & (~emit_mask_reg + K'(1));
    assign mask_left  = emit_mask_reg & ~sel_onehot;

    always_comb begin
        sel_code = 8'h00;
        for (int i = 0; i < K; i++) begin
            if (sel_onehot[i]) sel_code = emit_code_reg[i];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                case (kind_reg)
                    KIND_REPORT: state_next = (rpt_mask != '0) ? ST_EMIT : ST_IDLE;
                    KIND_TICK:   state_next = ST_TICK_CHECK;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_TICK_CHECK: begin
                state_next = tick_hit ? ST_TICK_CATCH : ST_IDLE;
            end
            ST_TICK_CATCH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load && (mask_left == '0)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        emit_mask_next   = emit_mask_reg;
        emit_code_next   = emit_code_reg;
        prev_keys_next   = prev_keys_reg;
        held_usage_next  = held_usage_reg;
        held_code_next   = held_code_reg;
        repeat_on_next   = repeat_on_reg;
        due_next         = due_reg;
        time_now_next    = time_now_reg;
        m_char_code_next = m_char_code_reg;
        m_last_next      = m_last_reg;
        m_valid_next     = m_ready ? 1'b0 : m_valid_reg;

        case (state_reg)
            ST_EVAL: begin
                case (kind_reg)
                    KIND_REPORT: begin
                        emit_mask_next = rpt_mask;
                        for (int i = 0; i < K; i++) begin
                            emit_code_next[i] = lane_res[i].code;
                        end
                        prev_keys_next  = key_reg;
                        repeat_on_next  = hold.on;
                        held_usage_next = hold.usage;
                        held_code_next  = hold.code;
                        if (hold.fresh) begin
                            due_next = time_now_reg + delay_eff;
                        end else if (!hold.on) begin
                            due_next = 32'd0;
                        end
                    end
                    KIND_TICK: begin
                        time_now_next = time_now_reg + 32'd1;
                    end
                    KIND_CLEAR: begin
                        prev_keys_next  = '0;
                        repeat_on_next  = 1'b0;
                        held_usage_next = 8'h00;
                        held_code_next  = 8'h00;
                        due_next        = 32'd0;
                    end
                    default: ;
                endcase
            end
            ST_TICK_CHECK: begin
                if (tick_hit) begin
                    emit_mask_next    = K'(1);
                    emit_code_next[0] = held_code_reg;
                    due_next          = due_reg + iv_eff;
                end
            end
            ST_TICK_CATCH: begin
                // fell behind by one interval or more: restart from now
                if (!due_diff[31]) due_next = time_now_reg + iv_eff;
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next     = 1'b1;
                    m_char_code_next = sel_code;
                    m_last_next      = (mask_left == '0);
                    emit_mask_next   = mask_left;
                end
            end
            default: ;
        endcase
    end

    // control and model state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            m_valid_reg         <= 1'b0;
            emit_mask_reg       <= '0;
            prev_keys_reg       <= '0;
            held_usage_reg      <= 8'h00;
            held_code_reg       <= 8'h00;
            repeat_on_reg       <= 1'b0;
            due_reg             <= 32'd0;
            time_now_reg        <= 32'd0;
            first_delay_reg     <= DEF_DELAY[15:0];
            repeat_interval_reg <= DEF_INTERVAL[15:0];
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            emit_mask_reg  <= emit_mask_next;
            prev_keys_reg  <= prev_keys_next;
            held_usage_reg <= held_usage_next;
            held_code_reg  <= held_code_next;
            repeat_on_reg  <= repeat_on_next;
            due_reg        <= due_next;
            time_now_reg   <= time_now_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FIRST_DELAY:     first_delay_reg     <= cfg_data;
                    CFG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg <= s_kind;
            mods_reg <= s_modifiers;
            key_reg  <= keys_in[K-1:0];
        end
        emit_code_reg   <= emit_code_next;
        m_char_code_reg <= m_char_code_next;
        m_last_reg      <= m_last_next;
    end

    // checks
    `HKR_ASSERT_NXT(a_accept_to_eval, aclk, aresetn, s_fire, state_reg == ST_EVAL)
    `HKR_ASSERT_IMP(a_idle_buffer_empty, aclk, aresetn, state_reg == ST_IDLE, emit_mask_reg == '0)
    `HKR_ASSERT_IMP(a_held_code_nz, aclk, aresetn, repeat_on_reg, held_code_reg != 8'h00)
    `HKR_ASSERT_IMP(a_held_usage_key, aclk, aresetn, repeat_on_reg, held_usage_reg > 8'd3)

endmodule
